// File: src/tlmm_pkg.sv
package tlmm_pkg;

   localparam int MotorCount = 4;
   localparam int SampleBits = 16;
   localparam int DivBits    = 48;

   localparam logic [1:0] PhaseCal   = 2'd0;
   localparam logic [1:0] PhaseRun   = 2'd1;
   localparam logic [1:0] PhaseFault = 2'd2;

   localparam logic [7:0] CalDuty  = 8'd28;
   localparam logic [7:0] ColorMid = 8'h60;
   localparam logic [7:0] ColorMax = 8'hFF;

   localparam logic [2:0] FaultIdentity = 3'd1;
   localparam logic [2:0] FaultCfgWrite = 3'd2;
   localparam logic [2:0] FaultCfgRead  = 3'd3;
   localparam logic [2:0] FaultSample   = 3'd4;

   localparam logic [2:0] RegHover   = 3'd0;
   localparam logic [2:0] RegFloor   = 3'd1;
   localparam logic [2:0] RegCeiling = 3'd2;
   localparam logic [2:0] RegAxisSm  = 3'd3;
   localparam logic [2:0] RegOutSm   = 3'd4;
   localparam logic [2:0] RegTiltDiv = 3'd5;
   localparam logic [2:0] RegDeadZn  = 3'd6;
   localparam logic [2:0] RegCalLen  = 3'd7;

   // start of a signed division, truncating toward zero
   typedef struct packed {
      logic                      start;
      logic signed [DivBits-1:0] dividend;
      logic [12:0]               divisor;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [DivBits-1:0] quotient;
   } div_rsp_type;

endpackage

// File: src/tlmm_divider.sv
module tlmm_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  tlmm_pkg::div_req_type div_req,
   output tlmm_pkg::div_rsp_type div_rsp
);
   import tlmm_pkg::*;

   localparam int CntBits = $clog2(DivBits + 1);

   logic                busy_ff, busy_in;
   logic                neg_ff, neg_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [DivBits-1:0]  quo_ff, quo_in;
   logic [13:0]         rem_ff, rem_in;
   logic [12:0]         den_ff, den_in;
   logic                done_ff, done_in;
   logic [14:0]         trial;
   logic [DivBits-1:0]  mag;

   always_comb begin
      busy_in = busy_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      mag     = div_req.dividend[DivBits-1] ? DivBits'(-div_req.dividend)
                                            : DivBits'(div_req.dividend);
      // one quotient bit per cycle
      trial   = {rem_ff, quo_ff[DivBits-1]} - {2'b00, den_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.dividend[DivBits-1];
         cnt_in  = CntBits'(DivBits);
         quo_in  = mag;
         rem_in  = '0;
         den_in  = (div_req.divisor == '0) ? 13'd1 : div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[14]) begin
            rem_in = trial[13:0];
            quo_in = {quo_ff[DivBits-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[12:0], quo_ff[DivBits-1]};
            quo_in = {quo_ff[DivBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntBits'(1);
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) quo_in = -quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: src/tilt_level_motor_mixer.sv
// Tilt-levelling mixer for an X quad. One sample per item, one result per item.
// All filter, average, tilt and blend divisions run one after another on one
// shared 48-step restoring divider. A failed read gives its result with no
// division; a calibration sample takes two filter divisions, and two averages
// more on its last sample; a running sample takes two filter, two tilt and four
// blend divisions. The result sits in an output register, and the next item
// is taken the cycle after the result has gone out. Registers should only be
// written while no item is in flight.
module tilt_level_motor_mixer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_read_ok,
   input  logic signed [15:0]     req_accel_x,
   input  logic signed [15:0]     req_accel_y,
   input  logic [2:0]             req_fault_kind,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_phase_now,
   output logic [7:0]             rsp_duty_front_left,
   output logic [7:0]             rsp_duty_front_right,
   output logic [7:0]             rsp_duty_rear_left,
   output logic [7:0]             rsp_duty_rear_right,
   output logic [7:0]             rsp_fault_red,
   output logic [7:0]             rsp_fault_green,
   output logic [7:0]             rsp_fault_blue,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [12:0]            csr_data
);
   import tlmm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_FSP, S_FSR, S_CBP, S_CBR, S_TLP, S_TLR, S_BLEND, S_OUT
   } state_type;

   typedef logic signed [DivBits-1:0] wide_type;

   state_type         state_ff, state_in;
   logic [7:0]  hover_ff, floor_ff, ceil_ff, dz_ff;
   logic [8:0]  axsm_ff, outsm_ff;
   logic [12:0] tdiv_ff, callen_ff;

   logic [1:0]         mode_ff, mode_in;
   logic signed [15:0] sp_ff, sp_in, sr_ff, sr_in, pb_ff, pb_in, rb_ff, rb_in;
   logic signed [31:0] pt_ff, pt_in, rt_ff, rt_in;
   logic [12:0]        cnt_ff, cnt_in;
   logic [7:0]         pres_ff [MotorCount], pres_in [MotorCount];
   logic [7:0]         goal_ff [MotorCount], goal_in [MotorCount];
   logic signed [15:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [17:0] pc_ff, pc_in;
   logic [1:0]         mot_ff, mot_in;
   logic               wait_ff, wait_in;
   logic [7:0]         r_ff, r_in, g_ff, g_in, b_ff, b_in;
   logic               rv_ff, rv_in;

   // roll command is kept for the mixing of all motors
   logic signed [17:0] rc_ff, rc_in;
   logic [7:0]         goal_mix [MotorCount];

   div_req_type dreq;
   div_rsp_type drsp;

   logic signed [17:0] qn;
   logic signed [17:0] cmd;
   logic [8:0]         ksm_a, ksm_o;
   logic signed [19:0] ps [MotorCount];
   logic signed [19:0] rs [MotorCount];

   assign ps = '{-20'sd1, -20'sd1, 20'sd1, 20'sd1};
   assign rs = '{20'sd1, -20'sd1, 20'sd1, -20'sd1};

   tlmm_divider u_div (.clock(clock), .reset(reset), .div_req(dreq), .div_rsp(drsp));

   function automatic logic signed [15:0] sext(input logic [15:0] v);
      logic [15:0] m;
      m = 16'((17'd1 << SampleBits) - 17'd1);
      sext = (v[SampleBits-1]) ? $signed(v | ~m) : $signed(v & m);
   endfunction

   assign ksm_a = (axsm_ff == '0) ? 9'd1 : axsm_ff;
   assign ksm_o = (outsm_ff == '0) ? 9'd1 : outsm_ff;
   // tilt quotients span more than 16 bits when the divisor is small
   assign qn    = 18'(drsp.quotient);
   assign cmd   = (qn > -$signed({10'd0, dz_ff}) && qn < $signed({10'd0, dz_ff}))
                  ? 18'sd0 : qn;

   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff; sp_in = sp_ff; sr_in = sr_ff; pb_in = pb_ff; rb_in = rb_ff;
      pt_in = pt_ff; rt_in = rt_ff; cnt_in = cnt_ff;
      pres_in = pres_ff; goal_in = goal_ff;
      ax_in = ax_ff; ay_in = ay_ff; pc_in = pc_ff; mot_in = mot_ff;
      wait_in = 1'b0;
      r_in = r_ff; g_in = g_ff; b_in = b_ff;
      rv_in = rv_ff && rsp_stall;
      dreq = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               r_in = '0; g_in = '0; b_in = '0;
               if (!req_read_ok) begin
                  mode_in = PhaseFault;
                  case (req_fault_kind)
                     FaultIdentity: r_in = ColorMax;
                     FaultCfgWrite: begin r_in = ColorMax; g_in = ColorMid; end
                     FaultCfgRead:  g_in = ColorMax;
                     FaultSample:   b_in = ColorMax;
                     default:       r_in = ColorMid;
                  endcase
                  state_in = S_OUT;
               end else begin
                  ax_in = sext(req_accel_x);
                  ay_in = sext(req_accel_y);
                  if (mode_ff == PhaseFault) begin
                     mode_in = PhaseCal; cnt_in = '0; pt_in = '0; rt_in = '0;
                  end
                  state_in = S_FSP;
                  wait_in  = 1'b1;
               end
            end
         end
         S_FSP, S_FSR: begin
            if (wait_ff) begin
               dreq.start    = 1'b1;
               dreq.dividend = (state_ff == S_FSP)
                  ? wide_type'(sp_ff) * wide_type'({1'b0, ksm_a} - 10'd1) + wide_type'(ax_ff)
                  : wide_type'(sr_ff) * wide_type'({1'b0, ksm_a} - 10'd1) + wide_type'(ay_ff);
               dreq.divisor  = {4'd0, ksm_a};
            end else if (drsp.done) begin
               if (state_ff == S_FSP) begin
                  sp_in = qn[15:0]; state_in = S_FSR; wait_in = 1'b1;
               end else begin
                  sr_in = qn[15:0];
                  if (mode_ff != PhaseRun) begin
                     pt_in  = pt_ff + 32'(sp_ff);
                     rt_in  = rt_ff + 32'(qn);
                     cnt_in = cnt_ff + 13'd1;
                     for (int m = 0; m < MotorCount; m++) begin
                        goal_in[m] = CalDuty; pres_in[m] = CalDuty;
                     end
                     if (cnt_in >= ((callen_ff == '0) ? 13'd1 : callen_ff)) begin
                        state_in = S_CBP; wait_in = 1'b1;
                     end else begin
                        state_in = S_OUT;
                     end
                  end else begin
                     state_in = S_TLP; wait_in = 1'b1;
                  end
               end
            end
         end
         S_CBP, S_CBR: begin
            if (wait_ff) begin
               dreq.start    = 1'b1;
               dreq.dividend = (state_ff == S_CBP) ? wide_type'(pt_ff) : wide_type'(rt_ff);
               dreq.divisor  = cnt_ff;
            end else if (drsp.done) begin
               if (state_ff == S_CBP) begin
                  pb_in = qn[15:0]; state_in = S_CBR; wait_in = 1'b1;
               end else begin
                  rb_in = qn[15:0]; mode_in = PhaseRun; state_in = S_OUT;
               end
            end
         end
         S_TLP, S_TLR: begin
            if (wait_ff) begin
               dreq.start    = 1'b1;
               dreq.dividend = (state_ff == S_TLP)
                  ? wide_type'(sp_ff) - wide_type'(pb_ff)
                  : wide_type'(sr_ff) - wide_type'(rb_ff);
               dreq.divisor  = tdiv_ff;
            end else if (drsp.done) begin
               if (state_ff == S_TLP) begin
                  pc_in = cmd; state_in = S_TLR; wait_in = 1'b1;
               end else begin
                  goal_in = goal_mix;
                  mot_in = '0;
                  state_in = S_BLEND; wait_in = 1'b1;
               end
            end
         end
         S_BLEND: begin
            if (wait_ff) begin
               dreq.start    = 1'b1;
               dreq.dividend = wide_type'({1'b0, pres_ff[mot_ff]}) *
                               wide_type'({1'b0, ksm_o} - 10'd1) +
                               wide_type'({1'b0, goal_ff[mot_ff]});
               dreq.divisor  = {4'd0, ksm_o};
            end else if (drsp.done) begin
               pres_in[mot_ff] = qn[7:0];
               if (mot_ff == 2'(MotorCount - 1)) begin
                  state_in = S_OUT;
               end else begin
                  mot_in = mot_ff + 2'd1; wait_in = 1'b1;
               end
            end
         end
         S_OUT: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rc_in = rc_ff;
      if (state_ff == S_TLR && !wait_ff && drsp.done) rc_in = cmd;
      for (int m = 0; m < MotorCount; m++) begin
         logic signed [19:0] t;
         t = $signed({12'd0, hover_ff}) + 20'(pc_ff) * ps[m] + 20'(rc_in) * rs[m];
         if (t < $signed({12'd0, floor_ff}))     goal_mix[m] = floor_ff;
         else if (t > $signed({12'd0, ceil_ff})) goal_mix[m] = ceil_ff;
         else                                    goal_mix[m] = t[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= PhaseCal;
         sp_ff <= '0; sr_ff <= '0; pb_ff <= '0; rb_ff <= '0;
         pt_ff <= '0; rt_ff <= '0; cnt_ff <= '0;
         for (int m = 0; m < MotorCount; m++) begin
            pres_ff[m] <= '0; goal_ff[m] <= '0;
         end
         rv_ff <= 1'b0; wait_ff <= 1'b0;
         hover_ff <= 8'd128; floor_ff <= 8'd0; ceil_ff <= 8'd255;
         axsm_ff <= 9'd8; outsm_ff <= 9'd4; tdiv_ff <= 13'd64;
         dz_ff <= 8'd2; callen_ff <= 13'd64;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         sp_ff <= sp_in; sr_ff <= sr_in; pb_ff <= pb_in; rb_ff <= rb_in;
         pt_ff <= pt_in; rt_ff <= rt_in; cnt_ff <= cnt_in;
         pres_ff <= pres_in;
         goal_ff <= goal_in;
         rv_ff <= rv_in; wait_ff <= wait_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               RegHover:   hover_ff  <= csr_data[7:0];
               RegFloor:   floor_ff  <= csr_data[7:0];
               RegCeiling: ceil_ff   <= csr_data[7:0];
               RegAxisSm:  axsm_ff   <= csr_data[8:0];
               RegOutSm:   outsm_ff  <= csr_data[8:0];
               RegTiltDiv: tdiv_ff   <= csr_data;
               RegDeadZn:  dz_ff     <= csr_data[7:0];
               RegCalLen:  callen_ff <= csr_data;
               default: ;
            endcase
         end
      end
      ax_ff <= ax_in; ay_ff <= ay_in; pc_ff <= pc_in; mot_ff <= mot_in;
      rc_ff <= rc_in;
      r_ff <= r_in; g_ff <= g_in; b_ff <= b_in;
   end

   assign rsp_phase_now        = mode_ff;
   assign rsp_duty_front_left  = pres_ff[0];
   assign rsp_duty_front_right = pres_ff[1];
   assign rsp_duty_rear_left   = pres_ff[2];
   assign rsp_duty_rear_right  = pres_ff[3];
   assign rsp_fault_red        = r_ff;
   assign rsp_fault_green      = g_ff;
   assign rsp_fault_blue       = b_ff;

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("item taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_phase_now)))
      else $error("result lost under stall");
   a_out_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |=> rsp_valid) else $error("result not shown");

endmodule

// File: tb/tilt_level_motor_mixer_test.sv
module tilt_level_motor_mixer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tlmm_pkg::*;

   localparam int StallLimit   = 6000;
   localparam int SettleCycles = 450;
   localparam int HoldCycles   = 700;

   localparam int PitchSign [MotorCount] = '{-1, -1, 1, 1};
   localparam int RollSign  [MotorCount] = '{1, -1, 1, -1};

   typedef struct {
      logic [1:0] phase;
      logic [7:0] duty [MotorCount];
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } mix_result_type;

   bit clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_read_ok = 0;
   logic signed [15:0] req_accel_x = 0;
   logic signed [15:0] req_accel_y = 0;
   logic [2:0] req_fault_kind = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_phase_now;
   logic [7:0] rsp_duty_front_left, rsp_duty_front_right;
   logic [7:0] rsp_duty_rear_left, rsp_duty_rear_right;
   logic [7:0] rsp_fault_red, rsp_fault_green, rsp_fault_blue;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = 0;
   logic [12:0] csr_data = 0;

   tilt_level_motor_mixer dut (.*);

   always begin
      clock = 1;
      #2;
      clock = 0;
      #2;
   end

   // predictor copy of configuration and state
   longint hover = 128, floor_duty = 0, ceil_duty = 255, axis_div = 8, blend_div = 4;
   longint tilt_div = 64, dead_zn = 2, cal_len = 64;
   logic [1:0] phase = PhaseCal;
   longint smooth_x = 0, smooth_y = 0, bias_pitch = 0, bias_roll = 0;
   longint sum_pitch = 0, sum_roll = 0, sample_count = 0;
   longint goal [MotorCount] = '{0, 0, 0, 0};
   longint present [MotorCount] = '{0, 0, 0, 0};

   mix_result_type expected_mix [$];
   int error_count = 0;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int hold_request = 0;

   function automatic longint nonzero(longint v);
      return v == 0 ? 1 : v;
   endfunction

   function automatic longint clear_small(longint c);
      return (c > -dead_zn && c < dead_zn) ? 0 : c;
   endfunction

   function automatic mix_result_type predict_mix(bit ok, logic signed [15:0] ax,
                                                  logic signed [15:0] ay, logic [2:0] kind);
      mix_result_type r;
      longint k, pc, rc, t;
      r.red = 0;
      r.green = 0;
      r.blue = 0;
      if (!ok) begin
         phase = PhaseFault;
         case (kind)
            FaultIdentity: r.red = ColorMax;
            FaultCfgWrite: begin
               r.red = ColorMax;
               r.green = ColorMid;
            end
            FaultCfgRead: r.green = ColorMax;
            FaultSample: r.blue = ColorMax;
            default: r.red = ColorMid;
         endcase
      end else begin
         if (phase == PhaseFault) begin
            phase = PhaseCal;
            sample_count = 0;
            sum_pitch = 0;
            sum_roll = 0;
         end
         k = nonzero(axis_div);
         smooth_x = (smooth_x * (k - 1) + longint'(ax)) / k;
         smooth_y = (smooth_y * (k - 1) + longint'(ay)) / k;
         if (phase != PhaseRun) begin
            sum_pitch += smooth_x;
            sum_roll += smooth_y;
            sample_count = (sample_count + 1) & 13'h1FFF;
            if (sample_count >= nonzero(cal_len)) begin
               bias_pitch = sum_pitch / sample_count;
               bias_roll = sum_roll / sample_count;
               phase = PhaseRun;
            end
            for (int m = 0; m < MotorCount; m++) begin
               goal[m] = CalDuty;
               present[m] = CalDuty;
            end
         end else begin
            pc = clear_small((smooth_x - bias_pitch) / nonzero(tilt_div));
            rc = clear_small((smooth_y - bias_roll) / nonzero(tilt_div));
            k = nonzero(blend_div);
            for (int m = 0; m < MotorCount; m++) begin
               t = hover + pc * PitchSign[m] + rc * RollSign[m];
               if (t < floor_duty) t = floor_duty;
               else if (t > ceil_duty) t = ceil_duty;
               goal[m] = t & 255;
               present[m] = ((present[m] * (k - 1) + goal[m]) / k) & 255;
            end
         end
      end
      r.phase = phase;
      for (int m = 0; m < MotorCount; m++) r.duty[m] = present[m][7:0];
      return r;
   endfunction

   task automatic send_sample(bit ok, logic signed [15:0] ax, logic signed [15:0] ay,
                              logic [2:0] kind);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_read_ok <= ok;
      req_accel_x <= ax;
      req_accel_y <= ay;
      req_fault_kind <= kind;
      do @(posedge clock); while (req_stall);
      expected_mix.push_back(predict_mix(ok, ax, ay, kind));
   endtask

   // lower valid and wait until every expected result is out
   task automatic wait_idle();
      req_valid <= 0;
      while (expected_mix.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [12:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
      case (idx)
         RegHover: hover = value & 8'hFF;
         RegFloor: floor_duty = value & 8'hFF;
         RegCeiling: ceil_duty = value & 8'hFF;
         RegAxisSm: axis_div = value & 9'h1FF;
         RegOutSm: blend_div = value & 9'h1FF;
         RegTiltDiv: tilt_div = value & 13'h1FFF;
         RegDeadZn: dead_zn = value & 8'hFF;
         default: cal_len = value & 13'h1FFF;
      endcase
   endtask

   function automatic logic [12:0] pick_value(logic [2:0] idx);
      int width;
      int typical;
      case (idx)
         RegHover: begin width = 8; typical = $urandom_range(90, 170); end
         RegFloor: begin width = 8; typical = $urandom_range(0, 60); end
         RegCeiling: begin width = 8; typical = $urandom_range(190, 255); end
         RegAxisSm: begin width = 9; typical = $urandom_range(1, 16); end
         RegOutSm: begin width = 9; typical = $urandom_range(1, 8); end
         RegTiltDiv: begin width = 13; typical = $urandom_range(1, 300); end
         RegDeadZn: begin width = 8; typical = $urandom_range(0, 6); end
         default: begin width = 13; typical = $urandom_range(1, 12); end
      endcase
      case ($urandom_range(9))
         0: return 13'd0;
         1: return 13'((1 << width) - 1);
         2: return 13'($urandom_range((1 << width) - 1));
         default: return 13'(typical);
      endcase
   endfunction

   task automatic random_settings();
      for (int i = 0; i < 8; i++) write_reg(3'(i), pick_value(3'(i)));
   endtask

   // mostly good samples near a random level, some full-range, a few failed reads
   task automatic random_samples(int count);
      int base_x, base_y;
      base_x = $urandom_range(0, 4000) - 2000;
      base_y = $urandom_range(0, 4000) - 2000;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(19))
            0: send_sample(0, 16'($urandom), 16'($urandom), 3'($urandom_range(7)));
            1, 2: send_sample(1, 16'($urandom), 16'($urandom), 3'($urandom_range(7)));
            default: send_sample(1, 16'(base_x + $urandom_range(0, 6000) - 3000),
                                 16'(base_y + $urandom_range(0, 6000) - 3000),
                                 3'($urandom_range(7)));
         endcase
      end
   endtask

   task automatic test_directed();
      logic [2:0] kinds [4] = '{FaultIdentity, FaultCfgWrite, FaultCfgRead, FaultSample};
      write_reg(RegCalLen, 0);
      write_reg(RegDeadZn, 0);
      send_sample(1, 16'sh7FFF, -16'sh8000, 0);
      send_sample(1, -16'sh8000, 16'sh7FFF, 7);
      send_sample(1, 0, 0, 0);
      for (int i = 0; i < 4; i++) send_sample(0, 16'sh7FFF, -1, kinds[i]);
      send_sample(0, -1, 16'sh7FFF, 0);
      send_sample(0, 0, 0, 3'd7);
      send_sample(1, 100, -100, 0);
      send_sample(1, 16'sh7FFF, 16'sh7FFF, 0);
      wait_idle();
      write_reg(RegFloor, 200);
      write_reg(RegCeiling, 50);
      write_reg(RegTiltDiv, 1);
      write_reg(RegAxisSm, 0);
      write_reg(RegOutSm, 0);
      send_sample(1, 16'sh7FFF, -16'sh8000, 0);
      send_sample(1, -16'sh8000, 16'sh7FFF, 0);
      send_sample(1, 5, 5, 0);
      wait_idle();
      write_reg(RegFloor, 0);
      write_reg(RegCeiling, 255);
      write_reg(RegTiltDiv, 0);
      write_reg(RegDeadZn, 255);
      write_reg(RegHover, 255);
      send_sample(1, 300, -300, 0);
      send_sample(1, -16'sh8000, -16'sh8000, 0);
      wait_idle();
      write_reg(RegCalLen, 4096);
      send_sample(0, 0, 0, FaultSample);
      repeat (6) send_sample(1, 16'($urandom), 16'($urandom), 0);
      wait_idle();
   endtask

   task automatic test_random(int settings, int per_setting);
      for (int s = 0; s < settings; s++) begin
         wait_idle();
         random_settings();
         random_samples(per_setting);
      end
   endtask

   task automatic test_backpressure();
      wait_idle();
      random_settings();
      write_reg(RegCalLen, 2);
      hold_request++;
      random_samples(40);
   endtask

   task automatic test_drain_pause();
      random_samples(30);
      wait_idle();
      random_samples(30);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_idle_pct = 9;
      recv_idle_pct = 76;
      test_directed();
      test_random(8, 62);
      send_idle_pct = 76;
      recv_idle_pct = 9;
      test_random(8, 62);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_drain_pause();
      test_random(9, 62);
      wait_idle();
      if (error_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // receiver stall, with an occasional long hold-off
   int hold_seen = 0, hold_left = 0;
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= $urandom_range(99) < recv_idle_pct;
      end
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      mix_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_mix.size() == 0) begin
            $error("result item with nothing expected");
            error_count++;
         end else begin
            e = expected_mix.pop_front();
            check_field("phase_now", e.phase, rsp_phase_now);
            check_field("duty_front_left", e.duty[0], rsp_duty_front_left);
            check_field("duty_front_right", e.duty[1], rsp_duty_front_right);
            check_field("duty_rear_left", e.duty[2], rsp_duty_rear_left);
            check_field("duty_rear_right", e.duty[3], rsp_duty_rear_right);
            check_field("fault_red", e.red, rsp_fault_red);
            check_field("fault_green", e.green, rsp_fault_green);
            check_field("fault_blue", e.blue, rsp_fault_blue);
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end
endmodule

// File: tilt_level_motor_mixer.f
src/tlmm_pkg.sv
src/tlmm_divider.sv
src/tilt_level_motor_mixer.sv
tb/tilt_level_motor_mixer_test.sv
